FILE: rtl/core/h263ph_pkg.sv
// ----------------------------------------------------------------------------
// h263ph_pkg
// shared types, field positions and the standard size table
// ----------------------------------------------------------------------------
package h263ph_pkg;

  // only the first twelve bytes of a picture can bear on the result
  localparam int PARSE_BYTES = 12;
  localparam int WIN_W       = PARSE_BYTES * 8;
  localparam int WIN_MSB     = WIN_W - 1;
  localparam int NBYTES_W    = 4;

  localparam int          START_BITS = 22;
  localparam logic [21:0] START_CODE = 22'h000020;

  localparam logic [2:0] FMT_CUSTOM   = 3'd6;
  localparam logic [2:0] FMT_EXTENDED = 3'd7;
  localparam logic [2:0] UFEP_KEEP    = 3'd0;
  localparam logic [2:0] UFEP_NEW     = 3'd1;

  // bit offsets from the first bit of the picture
  localparam int POS_TS      = 22;
  localparam int POS_MARKER  = 30;
  localparam int POS_ID      = 31;
  localparam int POS_FMT     = 35;
  localparam int POS_V1_TYPE = 38;
  localparam int POS_UFEP    = 38;
  localparam int POS_OPP_FMT = 41;
  localparam int POS_TYPE_U0 = 41;
  localparam int POS_TYPE_U1 = 59;
  localparam int POS_CUST_W  = 73;
  localparam int POS_CUST_H  = 83;

  // bytes that each header layout needs before it is complete
  localparam logic [NBYTES_W-1:0] NEED_V1     = 4'd5;
  localparam logic [NBYTES_W-1:0] NEED_KEEP   = 4'd7;
  localparam logic [NBYTES_W-1:0] NEED_STD    = 4'd9;
  localparam logic [NBYTES_W-1:0] NEED_CUSTOM = 4'd12;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [WIN_W-1:0]    bits;
    logic [NBYTES_W-1:0] nbytes;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [11:0] w;
    logic [10:0] h;
  } pic_size_t;

  // width in the upper twelve bits, height in the lower eleven
  function automatic pic_size_t size_lookup(input logic [2:0] fmt);
    pic_size_t s;
    case (fmt)
      3'd1:    s = {12'd128,  11'd96};
      3'd2:    s = {12'd176,  11'd144};
      3'd3:    s = {12'd352,  11'd288};
      3'd4:    s = {12'd704,  11'd576};
      3'd5:    s = {12'd1408, 11'd1152};
      default: s = {12'd0,    11'd0};
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/h263ph_front.sv
// ----------------------------------------------------------------------------
// h263ph_front
// collects picture bytes into the header window and issues a parse job
// ----------------------------------------------------------------------------
module h263ph_front #(
  parameter int HEADER_BYTES = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              q_full,
  output logic              push,
  output h263ph_pkg::job_t  job
);
  import h263ph_pkg::*;

  localparam int CNT_W = $clog2(HEADER_BYTES + 1);
  localparam int IDX_W = $clog2(HEADER_BYTES);

  logic [7:0]       header_window [HEADER_BYTES];
  logic [CNT_W-1:0] bytes_seen;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && last_byte;
  assign full     = (bytes_seen == CNT_W'(HEADER_BYTES));

  // snapshot of the window including the byte now arriving
  always_comb begin
    count_next = full ? bytes_seen : bytes_seen + CNT_W'(1);
    for (int i = 0; i < PARSE_BYTES; i++) begin
      if (!full && bytes_seen == CNT_W'(i)) begin
        job.bits[WIN_MSB - 8*i -: 8] = data_byte;
      end else begin
        job.bits[WIN_MSB - 8*i -: 8] = header_window[i];
      end
    end
    if (count_next >= CNT_W'(PARSE_BYTES)) begin
      job.nbytes = NBYTES_W'(PARSE_BYTES);
    end else begin
      job.nbytes = count_next[NBYTES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (accept) begin
      bytes_seen <= last_byte ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !full) begin
      header_window[bytes_seen[IDX_W-1:0]] <= data_byte;
    end
  end

endmodule

FILE: rtl/core/h263ph_queue.sv
// ----------------------------------------------------------------------------
// h263ph_queue
// short job queue between the byte collector and the header decoder
// ----------------------------------------------------------------------------
module h263ph_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  h263ph_pkg::job_t         push_job,
  input  logic                     pop,
  output h263ph_pkg::job_t         head,
  output h263ph_pkg::queue_stat_t  stat
);
  import h263ph_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  job_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat.full  = (fill == FILL_W'(QUEUE_DEPTH));
  assign stat.empty = (fill == '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: rtl/core/h263ph_back.sv
// ----------------------------------------------------------------------------
// h263ph_back
// decodes one header window into a result and holds it for the receiver
// ----------------------------------------------------------------------------
module h263ph_back (
  input  logic              clk,
  input  logic              rst,
  input  h263ph_pkg::job_t  head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [7:0]        timestamp,
  output logic [2:0]        source_format,
  output logic [2:0]        picture_type,
  output logic [11:0]       width,
  output logic [10:0]       height
);
  import h263ph_pkg::*;

  logic [WIN_W-1:0]    bits;
  logic [2:0]          fmt;
  logic [2:0]          ufep;
  logic [2:0]          opp_fmt;
  logic [9:0]          cust_w;
  logic                hdr_ok;
  logic                layout_ok;
  logic [NBYTES_W-1:0] need;
  logic [2:0]          fmt_d;
  logic [2:0]          type_d;
  logic [11:0]         w_d;
  logic [10:0]         h_d;
  pic_size_t           std_size;
  pic_size_t           opp_size;
  logic [11:0]         kept_width;
  logic [10:0]         kept_height;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    bits     = head.bits;
    fmt      = bits[WIN_MSB - POS_FMT -: 3];
    ufep     = bits[WIN_MSB - POS_UFEP -: 3];
    opp_fmt  = bits[WIN_MSB - POS_OPP_FMT -: 3];
    cust_w   = {1'b0, bits[WIN_MSB - POS_CUST_W -: 9]} + 10'd1;
    std_size = size_lookup(fmt);
    opp_size = size_lookup(opp_fmt);
    layout_ok = 1'b1;
    need     = NEED_V1;
    fmt_d    = fmt;
    type_d   = {2'b00, bits[WIN_MSB - POS_V1_TYPE]};
    w_d      = std_size.w;
    h_d      = std_size.h;
    if (fmt == FMT_CUSTOM || fmt == FMT_EXTENDED) begin
      if (ufep == UFEP_KEEP) begin
        need   = NEED_KEEP;
        type_d = bits[WIN_MSB - POS_TYPE_U0 -: 3];
        w_d    = kept_width;
        h_d    = kept_height;
      end else if (ufep == UFEP_NEW) begin
        fmt_d  = opp_fmt;
        type_d = bits[WIN_MSB - POS_TYPE_U1 -: 3];
        if (opp_fmt == FMT_CUSTOM) begin
          need = NEED_CUSTOM;
          w_d  = {cust_w, 2'b00};
          h_d  = {bits[WIN_MSB - POS_CUST_H -: 9], 2'b00};
        end else begin
          need = NEED_STD;
          w_d  = opp_size.w;
          h_d  = opp_size.h;
        end
      end else begin
        layout_ok = 1'b0;
      end
    end
    // bit values past the received bytes are covered by the length check
    hdr_ok = (bits[WIN_MSB -: START_BITS] == START_CODE)
          && bits[WIN_MSB - POS_MARKER]
          && !bits[WIN_MSB - POS_ID]
          && layout_ok
          && (head.nbytes >= need);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      kept_width  <= '0;
      kept_height <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (hdr_ok) begin
          kept_width  <= w_d;
          kept_height <= h_d;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ok            <= hdr_ok;
      timestamp     <= hdr_ok ? bits[WIN_MSB - POS_TS -: 8] : 8'd0;
      source_format <= hdr_ok ? fmt_d : 3'd0;
      picture_type  <= hdr_ok ? type_d : 3'd0;
      width         <= hdr_ok ? w_d : 12'd0;
      height        <= hdr_ok ? h_d : 11'd0;
    end
  end

endmodule

FILE: rtl/core/h263_picture_header_parser.sv
// ----------------------------------------------------------------------------
// h263_picture_header_parser
// picture header decoder: byte stream in, one decoded header per picture out
// ----------------------------------------------------------------------------
// input channel: in_valid / in_ready request carrying data_byte and last_byte,
//   bytes of one picture in order, most significant bit first
// output channel: out_valid / out_ready request carrying ok, timestamp,
//   source_format, picture_type, width and height
// one byte is taken per cycle while in_ready is high; non-final bytes only fill
//   the header window, bytes beyond HEADER_BYTES are dropped
// the final byte hands a snapshot of the window to a two-entry job queue;
//   the decoder pops one job per cycle while the output register is empty or
//   being taken, and the result passes from the queue entry into the output
//   register, where it waits until the receiver takes it
// with in_ready and out_ready high, throughput is one byte per cycle, set by
//   the window write port, and one-byte pictures give one result per cycle
// a stalled receiver holds the output register, the decoder stops popping,
//   and in_ready falls only once both queue entries are taken
// reset empties the queue, clears the byte count and the output valid, and
//   sets the kept picture size to zero
// ----------------------------------------------------------------------------
module h263_picture_header_parser #(
  parameter int HEADER_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [7:0]  timestamp,
  output logic [2:0]  source_format,
  output logic [2:0]  picture_type,
  output logic [11:0] width,
  output logic [10:0] height
);
  import h263ph_pkg::*;

  // job handed from the collector to the decoder
  job_t        push_job;
  job_t        head;
  logic        q_push;
  logic        q_pop;
  queue_stat_t qstat;

  // front: window fill and job issue on the final byte
  h263ph_front #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (qstat.full),
    .push      (q_push),
    .job       (push_job)
  );

  // queue lets the collector run on while the receiver stalls
  h263ph_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .stat     (qstat)
  );

  // back: field decode, size selection and output register
  h263ph_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (!qstat.empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .timestamp     (timestamp),
    .source_format (source_format),
    .picture_type  (picture_type),
    .width         (width),
    .height        (height)
  );

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("job pushed into a full queue");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("job popped from an empty queue");

  a_push_on_last : assert property (@(posedge clk) disable iff (rst)
    q_push |-> (in_valid && in_ready && last_byte))
    else $error("job issued without a final byte");

  a_zero_on_fail : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (timestamp == 8'd0 && source_format == 3'd0 &&
      picture_type == 3'd0 && width == 12'd0 && height == 11'd0))
    else $error("failed header carries non-zero fields");
`endif

endmodule
